>>> hdl/chained_hash_table_unit_assert.svh
// Assertion macros for the chained hash table unit.
// Expects clk and arst_n in the including scope; no other dependencies.
`ifndef CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CHT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CHT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CHT_ASSERT_IMP(lbl, ante, cons)
`define CHT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/cht_pkg.sv
// Shared constants, codes and types of the chained hash table unit.
// No dependencies.
package cht_pkg;
	localparam int BUCKETS = 16;
	localparam int ENTRIES = 64;
	localparam int BW = $clog2(BUCKETS);
	localparam int IW = $clog2(ENTRIES);
	localparam int NIW = IW + 1;
	localparam logic [NIW-1:0] NIL = NIW'(ENTRIES);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_REMOVED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic          push;
		logic          pop;
		logic [IW-1:0] push_idx;
	} free_ctl_t;
endpackage

>>> hdl/chained_hash_table_unit.sv
// Top level of the chained hash table unit: sequencer, bucket heads, node RAMs.
// Depends on cht_pkg, cht_ram, cht_free and chained_hash_table_unit_assert.svh.
//
// channel  | handshake            | words
// in       | in_valid / in_ready  | cmd, key, value
// out      | out_valid / out_ready| status, value_out
//
// Each word passes head read, a chain walk (one node compare per cycle, at most ENTRIES
// nodes), update, result and idle; the next word is accepted only back in idle.
// The result word is registered in the update state and offered in the result state.
// Reset empties all chains and fills the free stack at once; no clearing pass.
// in_ready is low from acceptance until the result word is taken, so out_ready stalls
// hold off the next word.
module chained_hash_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] key,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic signed [31:0] value_out
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOOK = 5'b00010,
		S_WALK = 5'b00100,
		S_ACT  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [1:0] cmd_q;
	logic [15:0] key_q;
	logic [31:0] value_q;
	logic [cht_pkg::NIW-1:0] head_q [cht_pkg::BUCKETS];
	logic [cht_pkg::IW-1:0] cur_q;
	logic [cht_pkg::NIW-1:0] prev_q;
	logic [cht_pkg::IW-1:0] steps_q;
	logic hit_q;
	logic [31:0] val_hit_q;
	logic [cht_pkg::NIW-1:0] nxt_hit_q;
	logic [2:0] status_q;
	logic [31:0] vout_q;

	logic [cht_pkg::BW-1:0] bkt;
	logic [cht_pkg::NIW-1:0] head_cur;
	logic [cht_pkg::IW-1:0] rd_addr;
	logic [15:0] key_rd;
	logic [31:0] val_rd;
	logic [cht_pkg::NIW-1:0] nxt_rd;
	logic [cht_pkg::NIW-1:0] fc;
	logic [cht_pkg::IW-1:0] new_n;
	logic act, ins, fnd, rem, can_ins, do_link;
	logic key_we, val_we, nxt_we;
	logic [cht_pkg::IW-1:0] val_waddr, nxt_waddr;
	logic [cht_pkg::NIW-1:0] nxt_wdata;
	cht_pkg::free_ctl_t fctl;
	logic [2:0] st_d;

	assign bkt = key_q[cht_pkg::BW-1:0];
	assign head_cur = head_q[bkt];
	assign rd_addr = (state_q == S_WALK) ? nxt_rd[cht_pkg::IW-1:0]
		: head_cur[cht_pkg::IW-1:0];

	assign act = (state_q == S_ACT);
	assign ins = (cmd_q == cht_pkg::CMD_INSERT);
	assign fnd = (cmd_q == cht_pkg::CMD_FIND);
	assign rem = (cmd_q == cht_pkg::CMD_REMOVE);
	assign can_ins = (fc != '0);
	assign do_link = act && ins && !hit_q && can_ins;

	assign key_we = do_link;
	assign val_we = act && ins && (hit_q || can_ins);
	assign val_waddr = hit_q ? cur_q : new_n;
	assign nxt_we = do_link || (act && rem && hit_q && (prev_q != cht_pkg::NIL));
	assign nxt_waddr = ins ? new_n : prev_q[cht_pkg::IW-1:0];
	assign nxt_wdata = ins ? head_cur : nxt_hit_q;

	assign fctl.pop = do_link;
	assign fctl.push = act && rem && hit_q && (fc < cht_pkg::NIL);
	assign fctl.push_idx = cur_q;

	cht_ram #(.WIDTH(16), .DEPTH(cht_pkg::ENTRIES)) u_key (
		.clk(clk), .we(key_we), .waddr(new_n), .wdata(key_q),
		.raddr(rd_addr), .rdata(key_rd)
	);

	cht_ram #(.WIDTH(32), .DEPTH(cht_pkg::ENTRIES)) u_val (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(value_q),
		.raddr(rd_addr), .rdata(val_rd)
	);

	cht_ram #(.WIDTH(cht_pkg::NIW), .DEPTH(cht_pkg::ENTRIES)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(rd_addr), .rdata(nxt_rd)
	);

	cht_free u_free (
		.clk(clk), .arst_n(arst_n), .ctl(fctl), .count(fc), .top(new_n)
	);

	always_comb begin
		case (cmd_q)
			cht_pkg::CMD_INSERT: st_d = hit_q ? cht_pkg::ST_UPDATED
				: (can_ins ? cht_pkg::ST_INSERTED : cht_pkg::ST_FULL);
			cht_pkg::CMD_FIND: st_d = hit_q ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
			cht_pkg::CMD_REMOVE: st_d = hit_q ? cht_pkg::ST_REMOVED : cht_pkg::ST_NOT_FOUND;
			default: st_d = cht_pkg::ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < cht_pkg::BUCKETS; i++)
				head_q[i] <= cht_pkg::NIL;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_LOOK;
				S_LOOK: state_q <= (head_cur >= cht_pkg::NIL) ? S_ACT : S_WALK;
				S_WALK: if (key_rd == key_q || nxt_rd >= cht_pkg::NIL
					|| steps_q == cht_pkg::IW'(cht_pkg::ENTRIES - 1)) state_q <= S_ACT;
				S_ACT: begin
					state_q <= S_OUT;
					if (do_link)
						head_q[bkt] <= {1'b0, new_n};
					else if (rem && hit_q && prev_q == cht_pkg::NIL)
						head_q[bkt] <= nxt_hit_q;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= cmd;
				key_q <= key;
				value_q <= value;
			end
			S_LOOK: begin
				hit_q <= 1'b0;
				cur_q <= head_cur[cht_pkg::IW-1:0];
				prev_q <= cht_pkg::NIL;
				steps_q <= '0;
			end
			S_WALK: begin
				if (key_rd == key_q) begin
					hit_q <= 1'b1;
					val_hit_q <= val_rd;
					nxt_hit_q <= nxt_rd;
				end else begin
					prev_q <= {1'b0, cur_q};
					cur_q <= nxt_rd[cht_pkg::IW-1:0];
					steps_q <= steps_q + cht_pkg::IW'(1);
				end
			end
			S_ACT: begin
				status_q <= st_d;
				vout_q <= (fnd && hit_q) ? val_hit_q : 32'd0;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = status_q;
	assign value_out = vout_q;

	`include "chained_hash_table_unit_assert.svh"

	`CHT_ASSERT_IMP(a_fc_bound, 1'b1, fc <= cht_pkg::NIL)
	`CHT_ASSERT_NXT(a_act_out, state_q == S_ACT, out_valid)
	`CHT_ASSERT_NXT(a_acc_look, in_valid && in_ready, state_q == S_LOOK)
	`CHT_ASSERT_IMP(a_pop_nonempty, fctl.pop, fc != '0 && !fctl.push)
endmodule

>>> hdl/cht_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> hdl/cht_free.sv
// Free node stack: stack RAM, per-entry written bits and the free count.
// Depends on cht_pkg and cht_ram.
module cht_free (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cht_pkg::free_ctl_t      ctl,
	output logic [cht_pkg::NIW-1:0] count,
	output logic [cht_pkg::IW-1:0]  top
);
	logic [cht_pkg::NIW-1:0] fc_q;
	logic [cht_pkg::ENTRIES-1:0] vld_q;
	logic [cht_pkg::IW-1:0] raddr;
	logic [cht_pkg::IW-1:0] ridx_q;
	logic rvld_q;
	logic [cht_pkg::IW-1:0] rdata;

	assign raddr = cht_pkg::IW'(fc_q - cht_pkg::NIW'(1));

	cht_ram #(.WIDTH(cht_pkg::IW), .DEPTH(cht_pkg::ENTRIES)) u_stack (
		.clk  (clk),
		.we   (ctl.push),
		.waddr(fc_q[cht_pkg::IW-1:0]),
		.wdata(ctl.push_idx),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= cht_pkg::NIL;
			vld_q <= '0;
		end else begin
			if (ctl.push) begin
				vld_q[fc_q[cht_pkg::IW-1:0]] <= 1'b1;
				fc_q <= fc_q + cht_pkg::NIW'(1);
			end else if (ctl.pop) begin
				fc_q <= fc_q - cht_pkg::NIW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= raddr;
		rvld_q <= vld_q[raddr];
	end

	assign count = fc_q;
	assign top = rvld_q ? rdata : ridx_q;
endmodule

>>> sim/tb_chained_hash_table_unit.sv
// Testbench for chained_hash_table_unit: directed table, pool fill and drain, then random traffic.
// Checks every result word against a behavioral chained hash table; uses cht_pkg.
module tb_chained_hash_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  c;
		logic [15:0] k;
		logic [31:0] v;
		bit          has_exp;
		logic [2:0]  st;
		logic [31:0] vo;
	} row_t;

	typedef struct {
		logic [2:0]  st;
		logic [31:0] vo;
	} res_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic [1:0] cmd = 0;
	logic [15:0] key = 0;
	logic signed [31:0] value = 0;
	logic in_ready, out_valid;
	logic [2:0] status;
	logic signed [31:0] value_out;

	chained_hash_table_unit uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// behavioral table
	int unsigned head [cht_pkg::BUCKETS];
	logic [15:0] nkey [cht_pkg::ENTRIES];
	logic [31:0] nval [cht_pkg::ENTRIES];
	int unsigned nnext [cht_pkg::ENTRIES];
	int unsigned fstack [cht_pkg::ENTRIES];
	int unsigned fcount;

	res_t pending_q[$];
	int errors = 0, n_words = 0, n_results = 0, n_full = 0, n_found = 0;
	bit quiet = 0, hold_off = 0;
	longint cycles = 0;

	function automatic void table_reset();
		for (int i = 0; i < cht_pkg::BUCKETS; i++) head[i] = cht_pkg::ENTRIES;
		for (int i = 0; i < cht_pkg::ENTRIES; i++) begin
			nnext[i] = cht_pkg::ENTRIES;
			fstack[i] = i;
		end
		fcount = cht_pkg::ENTRIES;
	endfunction

	function automatic res_t table_op(logic [1:0] c, logic [15:0] k, logic [31:0] v);
		res_t r;
		int unsigned b, cur, prev, hit, steps;
		r.st = cht_pkg::ST_NOT_FOUND;
		r.vo = 0;
		if (c == CMD_UNUSED) return r;
		b = k % cht_pkg::BUCKETS;
		cur = head[b];
		prev = cht_pkg::ENTRIES;
		hit = cht_pkg::ENTRIES;
		steps = 0;
		while (cur < cht_pkg::ENTRIES && steps < cht_pkg::ENTRIES) begin
			if (nkey[cur] == k) begin
				hit = cur;
				break;
			end
			prev = cur;
			cur = nnext[cur];
			steps++;
		end
		if (hit == cht_pkg::ENTRIES) prev = cht_pkg::ENTRIES;
		case (c)
			cht_pkg::CMD_INSERT: begin
				if (hit < cht_pkg::ENTRIES) begin
					nval[hit] = v;
					r.st = cht_pkg::ST_UPDATED;
				end else if (fcount == 0) begin
					r.st = cht_pkg::ST_FULL;
				end else begin
					fcount--;
					cur = fstack[fcount];
					nkey[cur] = k;
					nval[cur] = v;
					nnext[cur] = head[b];
					head[b] = cur;
					r.st = cht_pkg::ST_INSERTED;
				end
			end
			cht_pkg::CMD_FIND: if (hit < cht_pkg::ENTRIES) begin
				r.st = cht_pkg::ST_FOUND;
				r.vo = nval[hit];
			end
			cht_pkg::CMD_REMOVE: if (hit < cht_pkg::ENTRIES) begin
				if (prev < cht_pkg::ENTRIES) nnext[prev] = nnext[hit];
				else head[b] = nnext[hit];
				nnext[hit] = cht_pkg::ENTRIES;
				if (fcount < cht_pkg::ENTRIES) begin
					fstack[fcount] = hit;
					fcount++;
				end
				r.st = cht_pkg::ST_REMOVED;
			end
			default: ;
		endcase
		return r;
	endfunction

	// called at a falling edge; returns at a falling edge with in_valid still high
	task automatic send_word(logic [1:0] c, logic [15:0] k, logic [31:0] v,
			bit has_exp, logic [2:0] st, logic [31:0] vo);
		res_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		cmd <= c;
		key <= k;
		value <= v;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		r = table_op(c, k, v);
		if (has_exp && r.st !== st) begin
			$error("directed status exp %0d got %0d", st, r.st);
			errors++;
		end
		if (has_exp && r.vo !== vo) begin
			$error("directed value_out exp %h got %h", vo, r.vo);
			errors++;
		end
		pending_q.push_back(r);
		n_words++;
		@(negedge clk);
	endtask

	// receiver
	always begin
		int gap;
		@(negedge clk);
		if (hold_off) begin
			out_ready <= 0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			out_ready <= 0;
			repeat (gap - 1) @(negedge clk);
		end else begin
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		res_t e;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("result word with no expectation");
				errors++;
			end else begin
				e = pending_q.pop_front();
				n_results++;
				if (e.st == cht_pkg::ST_FULL) n_full++;
				if (e.st == cht_pkg::ST_FOUND) n_found++;
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
				if (value_out !== e.vo) begin
					$error("value_out exp %h got %h", e.vo, value_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) if (cycles > 2000000) begin
		$display("FAIL chained_hash_table_unit");
		$finish;
	end

	initial begin
		hold_off = 1;
		repeat (200) @(posedge clk);
		hold_off = 0;
	end

	row_t dir[$];
	logic [15:0] pool_keys[$];

	function automatic row_t mk(logic [1:0] c, logic [15:0] k, logic [31:0] v,
			bit h = 0, logic [2:0] st = 0, logic [31:0] vo = 0);
		row_t r;
		r.c = c; r.k = k; r.v = v; r.has_exp = h; r.st = st; r.vo = vo;
		return r;
	endfunction

	initial begin
		logic [1:0] c;
		logic [15:0] k;
		int sel;
		table_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		dir.push_back(mk(cht_pkg::CMD_FIND, 16'h0000, 0, 1, cht_pkg::ST_NOT_FOUND, 0));
		dir.push_back(mk(cht_pkg::CMD_REMOVE, 16'hFFFF, 0, 1, cht_pkg::ST_NOT_FOUND, 0));
		dir.push_back(mk(cht_pkg::CMD_INSERT, 16'h0000, 32'h8000_0000, 1,
			cht_pkg::ST_INSERTED, 0));
		dir.push_back(mk(cht_pkg::CMD_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 1,
			cht_pkg::ST_INSERTED, 0));
		dir.push_back(mk(cht_pkg::CMD_FIND, 16'h0000, 0, 1, cht_pkg::ST_FOUND,
			32'h8000_0000));
		dir.push_back(mk(cht_pkg::CMD_FIND, 16'hFFFF, 32'h1234, 1, cht_pkg::ST_FOUND,
			32'h7FFF_FFFF));
		dir.push_back(mk(cht_pkg::CMD_INSERT, 16'h0010, 32'hFFFF_FFFF, 1,
			cht_pkg::ST_INSERTED, 0));
		dir.push_back(mk(cht_pkg::CMD_INSERT, 16'h0000, 32'h5555_AAAA, 1,
			cht_pkg::ST_UPDATED, 0));
		dir.push_back(mk(cht_pkg::CMD_FIND, 16'h0000, 0, 1, cht_pkg::ST_FOUND,
			32'h5555_AAAA));
		dir.push_back(mk(cht_pkg::CMD_REMOVE, 16'h0000, 0, 1, cht_pkg::ST_REMOVED, 0));
		dir.push_back(mk(cht_pkg::CMD_FIND, 16'h0010, 0, 1, cht_pkg::ST_FOUND,
			32'hFFFF_FFFF));
		dir.push_back(mk(cht_pkg::CMD_FIND, 16'h0000, 0, 1, cht_pkg::ST_NOT_FOUND, 0));
		dir.push_back(mk(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1, cht_pkg::ST_NOT_FOUND, 0));
		dir.push_back(mk(CMD_UNUSED, 16'h0010, 0, 1, cht_pkg::ST_NOT_FOUND, 0));
		dir.push_back(mk(cht_pkg::CMD_REMOVE, 16'h0010, 0, 1, cht_pkg::ST_REMOVED, 0));
		dir.push_back(mk(cht_pkg::CMD_REMOVE, 16'hFFFF, 0, 1, cht_pkg::ST_REMOVED, 0));
		foreach (dir[i])
			send_word(dir[i].c, dir[i].k, dir[i].v, dir[i].has_exp, dir[i].st, dir[i].vo);

		// fill the pool to see pool full, then drain it
		for (int i = 0; i < cht_pkg::ENTRIES + 3; i++)
			send_word(cht_pkg::CMD_INSERT, 16'(i * 7 + 3), $urandom, 0, 0, 0);
		for (int i = 0; i < cht_pkg::ENTRIES + 3; i++)
			send_word(cht_pkg::CMD_REMOVE, 16'(i * 7 + 3), 0, 0, 0, 0);

		// random traffic over a small key set so chains and hits are common
		for (int i = 0; i < 40; i++) pool_keys.push_back(16'($urandom));
		for (int i = 0; i < 1600; i++) begin
			if (i > 1450) quiet = 1;
			sel = $urandom_range(0, 99);
			k = (sel < 85) ? pool_keys[$urandom_range(0, 39)] : 16'($urandom);
			if ($urandom_range(0, 19) == 0) k = pool_keys[0] ^ 16'h0010;
			c = 2'($urandom_range(0, 2));
			if ($urandom_range(0, 49) == 0) c = CMD_UNUSED;
			send_word(c, k, $urandom, 0, 0, 0);
		end
		in_valid <= 0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d words, checked %0d results (%0d found, %0d pool full).",
			n_words, n_results, n_found, n_full);
		if (errors == 0 && pending_q.size() == 0)
			$display("PASS chained_hash_table_unit");
		else
			$display("FAIL chained_hash_table_unit");
		$finish;
	end
endmodule
